// File: hdl/itc_pkg.sv
// types, codes and constants shared by the interval timer files
package itc_pkg;

    // number of counters that exist; they are numbered zero to two
    localparam int NUM_COUNTERS = 3;
    localparam logic [2:0] NUM_CNT_W = 3'(NUM_COUNTERS);

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_CTRL  = 2'd3;

    // read/load codes
    localparam logic [1:0] RL_LATCH = 2'b00;
    localparam logic [1:0] RL_LSB   = 2'b01;
    localparam logic [1:0] RL_MSB   = 2'b10;
    localparam logic [1:0] RL_BOTH  = 2'b11;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_SELECT = 2'd1;
    localparam logic [1:0] ST_LATCH_LOAD = 2'd2;

    localparam logic [5:0] MODE_MASK = 6'h3F;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] channel;
        logic [7:0] data;
    } itc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       gate_two_out;
        logic [1:0] status;
    } itc_out_t;

    typedef struct packed {
        logic [2:0][15:0] count;
        logic [2:0][15:0] latched;
        logic [2:0]       toggle;
        logic [2:0][5:0]  mode;
        logic             out_two;
    } itc_state_t;

endpackage

// File: hdl/interval_timer_three_counters_top.sv
// top level of the three-counter interval timer
//
// three 16-bit down counters with a per-counter mode word, latch and byte
// flip-flop. every transaction on the item channel (tick, counter read,
// counter write or control word) yields exactly one result transaction.
// a transaction is first captured in an input register; once the result
// register can accept it, a short single-pass datapath updates the timer
// state and writes the result register. the block takes one transaction
// per cycle as long as results are taken. item_stall rises only while the
// input register holds a transaction and the result register is full and
// stalled. counting is binary; the bcd bit is only stored. there are no
// configuration registers and no clear pass.
module interval_timer_three_counters_top (
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              item_valid,
    output logic              item_stall,
    input  itc_pkg::itc_in_t  item,
    // result channel
    output logic              result_valid,
    input  logic              result_stall,
    output itc_pkg::itc_out_t result
);
    import itc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    itc_in_t    in_reg;

    // timer state
    itc_state_t state_reg;
    itc_state_t state_next;

    itc_out_t   res;
    logic       out_free;
    logic       advance;
    logic       take;

    // a held transaction moves on when the result register can accept it
    assign advance       = in_valid_reg && out_free;
    assign item_stall    = in_valid_reg && !out_free;
    assign take          = item_valid && !item_stall;
    assign in_valid_next = take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= item;
    end

    // state only changes when its transaction is committed to the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    itc_exec u_exec (
        .item_in (in_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res)
    );

    itc_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .free         (out_free)
    );

endmodule

// File: hdl/itc_exec.sv
// single-pass datapath: next timer state and result for one transaction
module itc_exec (
    input  itc_pkg::itc_in_t    item_in,
    input  itc_pkg::itc_state_t cur,
    output itc_pkg::itc_state_t nxt,
    output itc_pkg::itc_out_t   res
);
    import itc_pkg::*;

    logic [1:0] c;
    logic [1:0] sel;
    logic [1:0] rl;
    logic [7:0] d;

    always_comb
    begin
        nxt = cur;
        res = '0;
        c   = item_in.channel;
        sel = item_in.data[7:6];
        d   = item_in.data;
        rl  = cur.mode[c][5:4];
        case (item_in.op)
            OP_TICK:
            begin
                for (int i = 0; i < NUM_COUNTERS; i++)
                begin
                    nxt.count[i] = cur.count[i] - 16'd1;
                    if (nxt.count[i] == 16'd0)
                    begin
                        if (i == 0)
                            res.timer_irq = 1'b1;
                        else if (i == 2)
                            nxt.out_two = 1'b0;
                    end
                end
            end
            OP_READ, OP_WRITE:
            begin
                if ({1'b0, c} >= NUM_CNT_W)
                    res.status = ST_BAD_SELECT;
                else if (item_in.op == OP_READ)
                begin
                    case (rl)
                        RL_LATCH:
                        begin
                            res.read_data = cur.toggle[c] ? cur.latched[c][15:8]
                                                          : cur.latched[c][7:0];
                            nxt.toggle[c] = ~cur.toggle[c];
                        end
                        RL_LSB:  res.read_data = cur.count[c][7:0];
                        RL_MSB:  res.read_data = cur.count[c][15:8];
                        default:
                        begin
                            res.read_data = cur.toggle[c] ? cur.count[c][15:8]
                                                          : cur.count[c][7:0];
                            nxt.toggle[c] = ~cur.toggle[c];
                        end
                    endcase
                end
                else
                begin
                    case (rl)
                        RL_LATCH: res.status = ST_LATCH_LOAD;
                        RL_LSB:   nxt.count[c] = {8'd0, d};
                        RL_MSB:   nxt.count[c] = {d, 8'd0};
                        default:
                        begin
                            if (cur.toggle[c])
                                nxt.count[c] = {d, cur.count[c][7:0]};
                            else
                                nxt.count[c] = {cur.count[c][15:8], d};
                            nxt.toggle[c] = ~cur.toggle[c];
                        end
                    endcase
                end
            end
            default:
            begin
                // control word: select in bits 7:6
                if ({1'b0, sel} >= NUM_CNT_W)
                    res.status = ST_BAD_SELECT;
                else
                begin
                    nxt.mode[sel] = d[5:0] & MODE_MASK;
                    if (d[5:4] == RL_LATCH)
                        nxt.latched[sel] = cur.count[sel];
                    if (sel == CNT_TWO)
                        nxt.out_two = (d[3:1] == 3'd0);
                end
            end
        endcase
        res.gate_two_out = nxt.out_two;
    end

endmodule

// File: hdl/itc_out_stage.sv
// result register with valid/stall handshake
module itc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  itc_pkg::itc_out_t res,
    input  logic              result_stall,
    output logic              result_valid,
    output itc_pkg::itc_out_t result,
    output logic              free
);
    import itc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    itc_out_t data_reg;

    assign free       = !valid_reg || !result_stall;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// File: hdl/itc_checker.sv
// port-level checker for the interval timer, bound to the top level
module itc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input itc_pkg::itc_out_t result
);
    import itc_pkg::*;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in    = item_valid && !item_stall;
    assign acc_out   = result_valid && !result_stall;
    assign pend_next = pend_reg + 2'(acc_in) - 2'(acc_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else
            pend_reg <= pend_next;
    end

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // no result without an accepted transaction behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result without pending transaction");

    // at most the input and result registers hold transactions
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many transactions in flight");

    // a flagged transaction returns no data and no interrupt
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK
            |-> result.read_data == 8'd0 && !result.timer_irq)
        else $error("error result carries data");

    // an item stall only follows a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled while result side free");

endmodule

bind interval_timer_three_counters_top itc_checker u_itc_checker (.*);
